[design/efir_pkg.sv]
package efir_pkg;

    localparam int ANGLE_BITS   = 24;
    localparam int DATA_BITS    = 32;
    localparam int CORDIC_STEPS = 30;
    localparam int TRIG_FRAC    = 30;
    localparam int CW           = 33;               // cordic x, y, z width
    localparam int TW           = 32;               // cos / sin width
    localparam int RW           = DATA_BITS + 3;    // rotated value before saturation
    localparam int EARTH_FRAC   = 32;

    // stage 0 angle prep, one stage per cordic step, fold, two lane stages, two merge stages
    localparam int PIPE_STAGES  = CORDIC_STEPS + 6;
    localparam int VEC_STAGES   = CORDIC_STEPS + 4;
    localparam int LANE_IN_STAGE = CORDIC_STEPS + 1;
    localparam int MERGE_IN_STAGE = CORDIC_STEPS + 3;

    localparam logic signed [CW-1:0] TRIG_GAIN     = 33'sd652032874;
    localparam logic signed [CW-1:0] TRIG_ONE      = 33'sd1073741824;
    localparam logic signed [CW-1:0] TRIG_MINUS    = -33'sd1073741824;
    localparam logic signed [31:0]   EARTH_RATE_Q32 = 32'sd1282842753;

    // arctangent of 2^-i in 2^-32 turn units
    localparam logic signed [CW-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
        33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
        33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
        33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
        33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
        33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
        33'sd652,       33'sd326,       33'sd163,       33'sd81,
        33'sd41,        33'sd20,        33'sd10,        33'sd5,
        33'sd3,         33'sd1
    };

    typedef struct packed {
        logic signed [DATA_BITS-1:0] pos_x;
        logic signed [DATA_BITS-1:0] pos_y;
        logic signed [DATA_BITS-1:0] pos_z;
        logic signed [DATA_BITS-1:0] vel_x;
        logic signed [DATA_BITS-1:0] vel_y;
        logic signed [DATA_BITS-1:0] vel_z;
        logic        [ANGLE_BITS-1:0] hour_angle;
    } in_t;

    typedef struct packed {
        logic signed [DATA_BITS-1:0] out_pos_x;
        logic signed [DATA_BITS-1:0] out_pos_y;
        logic signed [DATA_BITS-1:0] out_pos_z;
        logic signed [DATA_BITS-1:0] out_vel_x;
        logic signed [DATA_BITS-1:0] out_vel_y;
        logic signed [DATA_BITS-1:0] out_vel_z;
    } out_t;

    typedef struct packed {
        logic signed [DATA_BITS-1:0] pos_x;
        logic signed [DATA_BITS-1:0] pos_y;
        logic signed [DATA_BITS-1:0] pos_z;
        logic signed [DATA_BITS-1:0] vel_x;
        logic signed [DATA_BITS-1:0] vel_y;
        logic signed [DATA_BITS-1:0] vel_z;
    } vec_t;

    typedef struct packed {
        logic signed [TW-1:0] cos_val;
        logic signed [TW-1:0] sin_val;
        logic signed [TW-1:0] sin_neg;
    } trig_t;

    typedef struct packed {
        logic signed [RW-1:0] pos_x;
        logic signed [RW-1:0] pos_y;
        logic signed [RW-1:0] vel_x;
        logic signed [RW-1:0] vel_y;
    } rot_t;

    // clamp to the signed data range
    function automatic logic signed [DATA_BITS-1:0] sat_dw(input logic signed [RW:0] v);
        if (v[RW:DATA_BITS-1] == {(RW-DATA_BITS+2){v[RW]}}) begin
            sat_dw = v[DATA_BITS-1:0];
        end else if (v[RW]) begin
            sat_dw = {1'b1, {(DATA_BITS-1){1'b0}}};
        end else begin
            sat_dw = {1'b0, {(DATA_BITS-1){1'b1}}};
        end
    endfunction

endpackage

[design/efir_cordic.sv]
module efir_cordic (
    input  logic                            aclk,
    input  logic                            pipe_en,
    input  logic [efir_pkg::ANGLE_BITS-1:0] hour_angle,
    output efir_pkg::trig_t                 trig
);
    import efir_pkg::*;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } quad_t;

    logic signed [CW-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [CW-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [CW-1:0] z_reg [CORDIC_STEPS+1];
    quad_t                q_reg [CORDIC_STEPS+1];
    trig_t                trig_reg;
    trig_t                trig_next;

    logic [31:0]          a32;
    logic [31:0]          qsum;
    quad_t                q0;
    logic [31:0]          ru;
    logic signed [CW-1:0] xc;
    logic signed [CW-1:0] yc;
    logic signed [TW-1:0] xt;
    logic signed [TW-1:0] yt;

    // widen to a 32-bit binary angle and fold to the nearest quadrant
    assign a32  = 32'(hour_angle) << (32 - ANGLE_BITS);
    assign qsum = a32 + 32'h2000_0000;
    assign q0   = quad_t'(qsum[31:30]);
    assign ru   = a32 - {qsum[31:30], 30'd0};

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            x_reg[0] <= TRIG_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= {ru[31], ru};
            q_reg[0] <= q0;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                if (!z_reg[i][CW-1]) begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - ATAN_TURNS[i];
                end else begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + ATAN_TURNS[i];
                end
                q_reg[i+1] <= q_reg[i];
            end
        end
    end

    // clamp to unity, then undo the quadrant fold
    always_comb begin
        xc = x_reg[CORDIC_STEPS];
        yc = y_reg[CORDIC_STEPS];
        if (xc > TRIG_ONE) begin
            xc = TRIG_ONE;
        end else if (xc < TRIG_MINUS) begin
            xc = TRIG_MINUS;
        end
        if (yc > TRIG_ONE) begin
            yc = TRIG_ONE;
        end else if (yc < TRIG_MINUS) begin
            yc = TRIG_MINUS;
        end
        xt = xc[TW-1:0];
        yt = yc[TW-1:0];
        case (q_reg[CORDIC_STEPS])
            QUAD_1: begin
                trig_next.cos_val = -yt;
                trig_next.sin_val = xt;
            end
            QUAD_2: begin
                trig_next.cos_val = -xt;
                trig_next.sin_val = -yt;
            end
            QUAD_3: begin
                trig_next.cos_val = yt;
                trig_next.sin_val = -xt;
            end
            default: begin
                trig_next.cos_val = xt;
                trig_next.sin_val = yt;
            end
        endcase
        trig_next.sin_neg = -trig_next.sin_val;
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            trig_reg <= trig_next;
        end
    end

    assign trig = trig_reg;

endmodule

[design/efir_lane.sv]
module efir_lane (
    input  logic                                  aclk,
    input  logic                                  pipe_en,
    input  logic signed [efir_pkg::DATA_BITS-1:0] a,
    input  logic signed [efir_pkg::TW-1:0]        c,
    input  logic signed [efir_pkg::DATA_BITS-1:0] b,
    input  logic signed [efir_pkg::TW-1:0]        d,
    output logic signed [efir_pkg::RW-1:0]        r
);
    import efir_pkg::*;

    localparam int SP = DATA_BITS + TW;
    localparam logic [SP:0] HALF = (SP+1)'(1) << (TRIG_FRAC - 1);

    logic signed [SP-1:0] ac_reg;
    logic signed [SP-1:0] bd_reg;
    logic        [SP:0]   sum;
    logic signed [RW-1:0] r_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            ac_reg <= a * c;
            bd_reg <= b * d;
        end
    end

    // round half up, floor shift by the trig fraction
    assign sum = {ac_reg[SP-1], ac_reg} + {bd_reg[SP-1], bd_reg} + HALF;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            r_reg <= sum[TRIG_FRAC+RW-1:TRIG_FRAC];
        end
    end

    assign r = r_reg;

endmodule

[design/efir_merge.sv]
module efir_merge (
    input  logic                                  aclk,
    input  logic                                  pipe_en,
    input  efir_pkg::rot_t                        rot,
    input  logic signed [efir_pkg::DATA_BITS-1:0] pos_z,
    input  logic signed [efir_pkg::DATA_BITS-1:0] vel_z,
    output efir_pkg::out_t                        res
);
    import efir_pkg::*;

    localparam int MW = RW + 32;
    localparam logic [MW-1:0] HALF = MW'(1) << (EARTH_FRAC - 1);

    logic signed [MW-1:0]        mx_reg;
    logic signed [MW-1:0]        my_reg;
    rot_t                        rot_reg;
    logic signed [DATA_BITS-1:0] pz_reg;
    logic signed [DATA_BITS-1:0] vz_reg;
    out_t                        res_reg;

    logic [MW-1:0]        mx_rnd;
    logic [MW-1:0]        my_rnd;
    logic signed [RW-1:0] tx;
    logic signed [RW-1:0] ty;
    logic signed [RW:0]   ux;
    logic signed [RW:0]   uy;

    // earth rate times rotated position
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            mx_reg  <= rot.pos_y * EARTH_RATE_Q32;
            my_reg  <= rot.pos_x * EARTH_RATE_Q32;
            rot_reg <= rot;
            pz_reg  <= pos_z;
            vz_reg  <= vel_z;
        end
    end

    assign mx_rnd = mx_reg + HALF;
    assign my_rnd = my_reg + HALF;
    assign tx     = mx_rnd[EARTH_FRAC+RW-1:EARTH_FRAC];
    assign ty     = my_rnd[EARTH_FRAC+RW-1:EARTH_FRAC];
    assign ux     = {rot_reg.vel_x[RW-1], rot_reg.vel_x} - {tx[RW-1], tx};
    assign uy     = {rot_reg.vel_y[RW-1], rot_reg.vel_y} + {ty[RW-1], ty};

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            res_reg.out_pos_x <= sat_dw({rot_reg.pos_x[RW-1], rot_reg.pos_x});
            res_reg.out_pos_y <= sat_dw({rot_reg.pos_y[RW-1], rot_reg.pos_y});
            res_reg.out_pos_z <= pz_reg;
            res_reg.out_vel_x <= sat_dw(ux);
            res_reg.out_vel_y <= sat_dw(uy);
            res_reg.out_vel_z <= vz_reg;
        end
    end

    assign res = res_reg;

endmodule

[design/earth_fixed_to_inertial_rotation_top.sv]
// earth-fixed to inertial state vector rotation
//
// input channel s_valid / s_ready / s_payload: one word holds an earth-fixed
// position (1/16 m), velocity (2^-16 m/s) and a 24-bit greenwich hour angle
// result channel m_valid / m_ready / m_payload: one word with the inertial
// position and velocity; x and y saturate, z passes straight through
//
// throughput: one word per clock, sustained, while the receiver takes results
// path: the accepting edge loads the angle prep stage, then the word passes one
// stage per cordic step for 30 steps, the quadrant fold, two stages in the
// multiplier lanes, two stages in the earth-rate merge and the output register
// before m_valid
//
// the pipeline moves as one; it freezes only while both the output register
// and the skid register hold results, so s_ready stays high while a single
// result waits for m_ready
// reset clears all valid flags; the first word can be taken the cycle after
// aresetn goes high
module earth_fixed_to_inertial_rotation_top (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  efir_pkg::in_t    s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output efir_pkg::out_t   m_payload
);
    import efir_pkg::*;

    // per-stage valid flags, shifted along with the datapath
    logic [PIPE_STAGES-1:0] v_reg;
    logic                   pipe_en;

    // payload delay line that keeps position and velocity aligned with the trig
    vec_t                   vec_reg [VEC_STAGES];

    trig_t                  trig;
    rot_t                   rot;
    out_t                   pipe_res;
    logic                   pipe_valid;

    // output register plus skid register
    out_t                   m_payload_reg;
    logic                   m_valid_reg;
    out_t                   skid_reg;
    logic                   skid_valid_reg;
    logic                   take;

    assign pipe_en    = !skid_valid_reg;
    assign s_ready    = pipe_en;
    assign pipe_valid = v_reg[PIPE_STAGES-1];
    assign take       = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            vec_reg[0].pos_x <= s_payload.pos_x;
            vec_reg[0].pos_y <= s_payload.pos_y;
            vec_reg[0].pos_z <= s_payload.pos_z;
            vec_reg[0].vel_x <= s_payload.vel_x;
            vec_reg[0].vel_y <= s_payload.vel_y;
            vec_reg[0].vel_z <= s_payload.vel_z;
            for (int k = 1; k < VEC_STAGES; k++) begin
                vec_reg[k] <= vec_reg[k-1];
            end
        end
    end

    // sin / cos from the hour angle
    efir_cordic u_cordic (
        .aclk       (aclk),
        .pipe_en    (pipe_en),
        .hour_angle (s_payload.hour_angle),
        .trig       (trig)
    );

    // four rotation lanes: x' = x*cos - y*sin, y' = x*sin + y*cos
    efir_lane u_lane_pos_x (
        .aclk    (aclk),
        .pipe_en (pipe_en),
        .a       (vec_reg[LANE_IN_STAGE].pos_x),
        .c       (trig.cos_val),
        .b       (vec_reg[LANE_IN_STAGE].pos_y),
        .d       (trig.sin_neg),
        .r       (rot.pos_x)
    );

    efir_lane u_lane_pos_y (
        .aclk    (aclk),
        .pipe_en (pipe_en),
        .a       (vec_reg[LANE_IN_STAGE].pos_x),
        .c       (trig.sin_val),
        .b       (vec_reg[LANE_IN_STAGE].pos_y),
        .d       (trig.cos_val),
        .r       (rot.pos_y)
    );

    efir_lane u_lane_vel_x (
        .aclk    (aclk),
        .pipe_en (pipe_en),
        .a       (vec_reg[LANE_IN_STAGE].vel_x),
        .c       (trig.cos_val),
        .b       (vec_reg[LANE_IN_STAGE].vel_y),
        .d       (trig.sin_neg),
        .r       (rot.vel_x)
    );

    efir_lane u_lane_vel_y (
        .aclk    (aclk),
        .pipe_en (pipe_en),
        .a       (vec_reg[LANE_IN_STAGE].vel_x),
        .c       (trig.sin_val),
        .b       (vec_reg[LANE_IN_STAGE].vel_y),
        .d       (trig.cos_val),
        .r       (rot.vel_y)
    );

    // earth-rate correction of the velocity and saturation
    efir_merge u_merge (
        .aclk    (aclk),
        .pipe_en (pipe_en),
        .rot     (rot),
        .pos_z   (vec_reg[MERGE_IN_STAGE].pos_z),
        .vel_z   (vec_reg[MERGE_IN_STAGE].vel_z),
        .res     (pipe_res)
    );

    // control: valid shift, output and skid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg          <= '0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (pipe_en) begin
                v_reg <= {v_reg[PIPE_STAGES-2:0], s_valid};
            end
            if (take) begin
                // skid drains first; the pipe is frozen while it is full
                m_valid_reg    <= skid_valid_reg || pipe_valid;
                skid_valid_reg <= 1'b0;
            end else if (pipe_en && pipe_valid) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // result words
    always_ff @(posedge aclk) begin
        if (take) begin
            m_payload_reg <= skid_valid_reg ? skid_reg : pipe_res;
        end else if (pipe_en) begin
            skid_reg <= pipe_res;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

[design/efir_checker.sv]
module efir_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input efir_pkg::out_t m_payload
);
    import efir_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result word changed while stalled");

    // after reset the block is empty and ready
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not empty after reset");

    // input side only closes while a result is held at the output
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

    // input side closes only after the receiver stalled a result
    a_ready_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(m_valid && !m_ready))
        else $error("input stalled without a receiver stall");

    // a taken result reopens the input side
    a_ready_back: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready && m_ready |=> s_ready)
        else $error("input not reopened after result taken");

endmodule

bind earth_fixed_to_inertial_rotation_top efir_checker u_efir_checker (.*);
